>>> rtl/core/rsi_pkg.sv
package rsi_pkg;

  // discriminant tolerance register
  localparam int unsigned EPS_W = 32;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd1;

  localparam int unsigned COUNT_W = 2;
  localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

  // which numerator feeds the final divide
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ONE,
    MODE_NEAR,
    MODE_FAR
  } root_mode_t;

endpackage

>>> rtl/core/ray_sphere_intersect.sv
// throughput: one beat per cycle while in_stall is low, set by a fully pipelined datapath
//   with a sqrt stage per root bit and a divide stage per distance bit
// output skid register lets one more beat drain when the result side stalls
// reset: synchronous active-low rst_n clears all valid bits, eps_r resets to 1
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [EPS_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic [COORD_WIDTH-2:0]        in_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [COORD_WIDTH-2:0]        out_distance,
  output logic [COUNT_W-1:0]            out_root_count
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned OC_W   = CW + 1;
  localparam int unsigned DD_W   = 2 * CW;
  localparam int unsigned DO_W   = 2 * CW + 1;
  localparam int unsigned OO_W   = 2 * CW + 2;
  localparam int unsigned RR_W   = 2 * CW - 2;
  localparam int unsigned A_W    = 2 * CW;
  localparam int unsigned B_W    = 2 * CW + 3;
  localparam int unsigned C_W    = 2 * CW + 3;
  localparam int unsigned BM_W   = 2 * CW + 2;
  localparam int unsigned H_W    = CW + 1;
  localparam int unsigned PB_W   = 2 * H_W;
  localparam int unsigned PA_W   = CW + H_W;
  localparam int unsigned BSQ_W  = 2 * BM_W;
  localparam int unsigned AC_W   = A_W + BM_W;
  localparam int unsigned D_W    = 4 * CW + 5;
  localparam int unsigned RT_W   = 2 * CW + 2;
  localparam int unsigned SQ_W   = 2 * RT_W;
  localparam int unsigned NUM_W  = 2 * CW + 3;
  localparam int unsigned NS_W   = NUM_W + 1;
  localparam int unsigned X_W    = NUM_W + FRAC_BITS;
  localparam int unsigned CMP_W  = X_W + A_W + CW;
  localparam int unsigned Q_W    = CW - 1;
  localparam int unsigned Y_W    = A_W + 1;
  localparam int unsigned SS_W   = BM_W + 1 + A_W + 2 + 1 + COUNT_W;
  localparam int unsigned DS_W   = 2 + COUNT_W;

  logic en;
  logic out_free;

  // ---------------------------------------------------------------------------
  // configuration register
  logic [EPS_W-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: origin minus center
  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  logic signed [CW-1:0] c_in [3];

  assign o_in[0] = in_origin_x;
  assign o_in[1] = in_origin_y;
  assign o_in[2] = in_origin_z;
  assign d_in[0] = in_dir_x;
  assign d_in[1] = in_dir_y;
  assign d_in[2] = in_dir_z;
  assign c_in[0] = in_center_x;
  assign c_in[1] = in_center_y;
  assign c_in[2] = in_center_z;

  logic                   s1_v_r;
  logic signed [CW-1:0]   s1_d_r  [3];
  logic signed [OC_W-1:0] s1_oc_r [3];
  logic [CW-2:0]          s1_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_d_r[k]  <= d_in[k];
        s1_oc_r[k] <= OC_W'(o_in[k]) - OC_W'(c_in[k]);
      end
      s1_rad_r <= in_radius;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: per-axis products
  logic                   s2_v_r;
  logic signed [DD_W-1:0] s2_dd_r [3];
  logic signed [DO_W-1:0] s2_do_r [3];
  logic signed [OO_W-1:0] s2_oo_r [3];
  logic [RR_W-1:0]        s2_rr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_dd_r[k] <= DD_W'(s1_d_r[k]) * DD_W'(s1_d_r[k]);
        s2_do_r[k] <= DO_W'(s1_d_r[k]) * DO_W'(s1_oc_r[k]);
        s2_oo_r[k] <= OO_W'(s1_oc_r[k]) * OO_W'(s1_oc_r[k]);
      end
      s2_rr_r <= RR_W'(s1_rad_r) * RR_W'(s1_rad_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: quadratic coefficients a, b, c
  logic                  s3_v_r;
  logic [A_W-1:0]        s3_a_r;
  logic signed [B_W-1:0] s3_b_r;
  logic signed [C_W-1:0] s3_c_r;
  logic [A_W-1:0]        a_sum;
  logic signed [B_W-1:0] b_sum;
  logic signed [C_W-1:0] c_sum;

  assign a_sum = A_W'($unsigned(s2_dd_r[0])) + A_W'($unsigned(s2_dd_r[1]))
               + A_W'($unsigned(s2_dd_r[2]));
  assign b_sum = B_W'(s2_do_r[0]) + B_W'(s2_do_r[1]) + B_W'(s2_do_r[2]);
  assign c_sum = C_W'(s2_oo_r[0]) + C_W'(s2_oo_r[1]) + C_W'(s2_oo_r[2])
               - $signed(C_W'(s2_rr_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r <= a_sum;
      s3_b_r <= b_sum <<< 1;
      s3_c_r <= c_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: magnitudes and split partial products for b*b and a*|c|
  logic [BM_W-1:0] bm;
  logic [BM_W-1:0] cm;
  logic [B_W-1:0]  b_neg;
  logic [C_W-1:0]  c_neg;

  assign b_neg = -s3_b_r;
  assign c_neg = -s3_c_r;
  assign bm    = s3_b_r[B_W-1] ? b_neg[BM_W-1:0] : BM_W'($unsigned(s3_b_r));
  assign cm    = s3_c_r[C_W-1] ? c_neg[BM_W-1:0] : BM_W'($unsigned(s3_c_r));

  logic            s4_v_r;
  logic [PB_W-1:0] s4_pb_ll_r;
  logic [PB_W-1:0] s4_pb_lh_r;
  logic [PB_W-1:0] s4_pb_hh_r;
  logic [PA_W-1:0] s4_pa_ll_r;
  logic [PA_W-1:0] s4_pa_lh_r;
  logic [PA_W-1:0] s4_pa_hl_r;
  logic [PA_W-1:0] s4_pa_hh_r;
  logic [A_W-1:0]  s4_a_r;
  logic [BM_W-1:0] s4_bm_r;
  logic            s4_b_pos_r;
  logic            s4_c_neg_r;
  logic            s4_c_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pb_ll_r  <= PB_W'(bm[H_W-1:0]) * PB_W'(bm[H_W-1:0]);
      s4_pb_lh_r  <= PB_W'(bm[H_W-1:0]) * PB_W'(bm[BM_W-1:H_W]);
      s4_pb_hh_r  <= PB_W'(bm[BM_W-1:H_W]) * PB_W'(bm[BM_W-1:H_W]);
      s4_pa_ll_r  <= PA_W'(s3_a_r[CW-1:0]) * PA_W'(cm[H_W-1:0]);
      s4_pa_lh_r  <= PA_W'(s3_a_r[CW-1:0]) * PA_W'(cm[BM_W-1:H_W]);
      s4_pa_hl_r  <= PA_W'(s3_a_r[A_W-1:CW]) * PA_W'(cm[H_W-1:0]);
      s4_pa_hh_r  <= PA_W'(s3_a_r[A_W-1:CW]) * PA_W'(cm[BM_W-1:H_W]);
      s4_a_r      <= s3_a_r;
      s4_bm_r     <= bm;
      s4_b_pos_r  <= !s3_b_r[B_W-1] && (s3_b_r != '0);
      s4_c_neg_r  <= s3_c_r[C_W-1];
      s4_c_zero_r <= (s3_c_r == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: recombine partial products
  logic             s5_v_r;
  logic [BSQ_W-1:0] s5_bsq_r;
  logic [AC_W-1:0]  s5_ac_r;
  logic [A_W-1:0]   s5_a_r;
  logic [BM_W-1:0]  s5_bm_r;
  logic             s5_b_pos_r;
  logic             s5_c_neg_r;
  logic             s5_c_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_bsq_r    <= BSQ_W'(s4_pb_ll_r) + (BSQ_W'(s4_pb_lh_r) << (H_W + 1))
                   + (BSQ_W'(s4_pb_hh_r) << (2 * H_W));
      s5_ac_r     <= AC_W'(s4_pa_ll_r) + (AC_W'(s4_pa_lh_r) << H_W)
                   + (AC_W'(s4_pa_hl_r) << CW) + (AC_W'(s4_pa_hh_r) << (CW + H_W));
      s5_a_r      <= s4_a_r;
      s5_bm_r     <= s4_bm_r;
      s5_b_pos_r  <= s4_b_pos_r;
      s5_c_neg_r  <= s4_c_neg_r;
      s5_c_zero_r <= s4_c_zero_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: discriminant
  logic                  s6_v_r;
  logic signed [D_W-1:0] s6_d_r;
  logic [A_W-1:0]        s6_a_r;
  logic [BM_W-1:0]       s6_bm_r;
  logic                  s6_b_pos_r;
  logic                  s6_c_neg_r;
  logic                  s6_c_zero_r;
  logic [D_W-1:0]        bsq_x;
  logic [D_W-1:0]        ac4_x;

  assign bsq_x = D_W'(s5_bsq_r);
  assign ac4_x = D_W'(s5_ac_r) << 2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_d_r      <= s5_c_neg_r ? $signed(bsq_x + ac4_x) : $signed(bsq_x - ac4_x);
      s6_a_r      <= s5_a_r;
      s6_bm_r     <= s5_bm_r;
      s6_b_pos_r  <= s5_b_pos_r;
      s6_c_neg_r  <= s5_c_neg_r;
      s6_c_zero_r <= s5_c_zero_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: classify roots against the tolerance
  logic signed [D_W-1:0] eps_x;
  logic                  d_gt;
  logic                  d_tan;
  logic                  a_zero;
  logic                  nb_ok;
  logic                  c_ge;
  logic                  c_le;
  root_mode_t            mode;
  logic                  hit;
  logic [COUNT_W-1:0]    count;

  assign eps_x  = $signed(D_W'(eps_r));
  assign d_gt   = (s6_d_r > eps_x);
  assign d_tan  = !d_gt && (s6_d_r >= -eps_x);
  assign a_zero = (s6_a_r == '0);
  assign nb_ok  = !s6_b_pos_r;
  assign c_ge   = !s6_c_neg_r;
  assign c_le   = s6_c_neg_r || s6_c_zero_r;

  always_comb begin
    mode  = MODE_NONE;
    hit   = 1'b0;
    count = COUNT_NONE;
    if (!a_zero) begin
      if (d_gt) begin
        count = COUNT_TWO;
        if (nb_ok && c_ge) begin
          mode = MODE_NEAR;
          hit  = 1'b1;
        end else if (nb_ok || c_le) begin
          mode = MODE_FAR;
          hit  = 1'b1;
        end
      end else if (d_tan) begin
        count = COUNT_ONE;
        if (nb_ok) begin
          mode = MODE_ONE;
          hit  = 1'b1;
        end
      end
    end
  end

  logic                  s7_v_r;
  logic [SQ_W-1:0]       s7_x_r;
  logic [SS_W-1:0]       s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_x_r    <= s6_d_r[SQ_W-1:0];
      s7_side_r <= {s6_bm_r, s6_b_pos_r, s6_a_r, mode, hit, count};
    end
  end

  // ---------------------------------------------------------------------------
  // square root of the discriminant
  logic             sq_v;
  logic [RT_W-1:0]  sq_root;
  logic [SS_W-1:0]  sq_side;

  rsi_sqrt_pipe #(
    .RW     (RT_W),
    .SIDE_W (SS_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_x      (s7_x_r),
    .in_side   (s7_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic [BM_W-1:0]    sq_bm;
  logic               sq_b_pos;
  logic [A_W-1:0]     sq_a;
  root_mode_t         sq_mode;
  logic               sq_hit;
  logic [COUNT_W-1:0] sq_count;

  assign {sq_bm, sq_b_pos, sq_a, sq_mode, sq_hit, sq_count} = sq_side;

  // ---------------------------------------------------------------------------
  // numerator select: -b minus root, -b plus root, -b alone, or zero when there is no hit
  logic signed [NS_W-1:0] neg_b;
  logic signed [NS_W-1:0] root_x;
  logic signed [NS_W-1:0] num;

  assign neg_b  = sq_b_pos ? -$signed(NS_W'(sq_bm)) : $signed(NS_W'(sq_bm));
  assign root_x = $signed(NS_W'(sq_root));

  always_comb begin
    unique case (sq_mode)
      MODE_NEAR: num = neg_b - root_x;
      MODE_FAR:  num = neg_b + root_x;
      MODE_ONE:  num = neg_b;
      default:   num = '0;
    endcase
  end

  logic               sn_v_r;
  logic [NUM_W-1:0]   sn_num_r;
  logic [A_W-1:0]     sn_a_r;
  logic               sn_hit_r;
  logic [COUNT_W-1:0] sn_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sn_v_r <= 1'b0;
    end else if (en) begin
      sn_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_num_r   <= num[NUM_W-1:0];
      sn_a_r     <= sq_a;
      sn_hit_r   <= sq_hit;
      sn_count_r <= sq_count;
    end
  end

  // ---------------------------------------------------------------------------
  // scale numerator, detect saturation, seed the divider
  logic [X_W-1:0]   x_scaled;
  logic [X_W-1:0]   x_top;
  logic             ovf;

  assign x_scaled = X_W'(sn_num_r) << FRAC_BITS;
  assign x_top    = x_scaled >> Q_W;
  assign ovf      = (CMP_W'(x_scaled) >= (CMP_W'(sn_a_r) << CW));

  logic               so_v_r;
  logic [Y_W-1:0]     so_rem_r;
  logic [Q_W-1:0]     so_low_r;
  logic [Y_W-1:0]     so_div_r;
  logic [DS_W-1:0]    so_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_v_r <= 1'b0;
    end else if (en) begin
      so_v_r <= sn_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so_rem_r  <= x_top[Y_W-1:0];
      so_low_r  <= x_scaled[Q_W-1:0];
      so_div_r  <= {sn_a_r, 1'b0};
      so_side_r <= {sn_hit_r, ovf, sn_count_r};
    end
  end

  // ---------------------------------------------------------------------------
  // divide by 2a
  logic             dv_v;
  logic [Q_W-1:0]   dv_quo;
  logic [DS_W-1:0]  dv_side;

  rsi_div_pipe #(
    .YW     (Y_W),
    .QW     (Q_W),
    .SIDE_W (DS_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (so_v_r),
    .in_rem    (so_rem_r),
    .in_low    (so_low_r),
    .in_div    (so_div_r),
    .in_side   (so_side_r),
    .out_valid (dv_v),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  logic               dv_hit;
  logic               dv_ovf;
  logic [COUNT_W-1:0] dv_count;

  assign {dv_hit, dv_ovf, dv_count} = dv_side;

  // ---------------------------------------------------------------------------
  // final result stage with saturation
  logic               p_v_r;
  logic               p_hit_r;
  logic [Q_W-1:0]     p_dist_r;
  logic [COUNT_W-1:0] p_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hit_r   <= dv_hit;
      p_dist_r  <= !dv_hit ? '0 : (dv_ovf ? '1 : dv_quo);
      p_count_r <= dv_count;
    end
  end

  // ---------------------------------------------------------------------------
  // output register with one skid entry
  logic               out_valid_r;
  logic               out_hit_r;
  logic [Q_W-1:0]     out_dist_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               skid_valid_r;
  logic               skid_hit_r;
  logic [Q_W-1:0]     skid_dist_r;
  logic [COUNT_W-1:0] skid_count_r;

  assign en       = !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= p_v_r;
      end
    end else if (p_v_r && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_hit_r   <= skid_hit_r;
        out_dist_r  <= skid_dist_r;
        out_count_r <= skid_count_r;
      end else begin
        out_hit_r   <= p_hit_r;
        out_dist_r  <= p_dist_r;
        out_count_r <= p_count_r;
      end
    end else if (!skid_valid_r) begin
      skid_hit_r   <= p_hit_r;
      skid_dist_r  <= p_dist_r;
      skid_count_r <= p_count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_distance   = out_dist_r;
  assign out_root_count = out_count_r;

endmodule

>>> rtl/core/rsi_sqrt_pipe.sv
module rsi_sqrt_pipe #(
  parameter int unsigned RW     = 66,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*RW-1:0]     in_x,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [RW-1:0]       out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int unsigned SW = 2 * RW;

  logic              v_r    [RW];
  logic [SW-1:0]     x_r    [RW];
  logic [RW-1:0]     root_r [RW];
  logic [RW:0]       rem_r  [RW];
  logic [SIDE_W-1:0] side_r [RW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar gi = 0; gi < RW; gi++) begin : g_stage
    logic              vi;
    logic [SW-1:0]     xi;
    logic [RW-1:0]     ri;
    logic [RW:0]       mi;
    logic [SIDE_W-1:0] si;
    logic [RW+2:0]     rem2;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;
    logic              ge;

    if (gi == 0) begin : g_first
      assign vi = in_valid;
      assign xi = in_x;
      assign ri = '0;
      assign mi = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[gi-1];
      assign xi = x_r[gi-1];
      assign ri = root_r[gi-1];
      assign mi = rem_r[gi-1];
      assign si = side_r[gi-1];
    end

    assign rem2  = {mi, xi[SW-1 -: 2]};
    assign trial = {1'b0, ri, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else if (en) begin
        v_r[gi] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[gi]    <= {xi[SW-3:0], 2'b00};
        root_r[gi] <= {ri[RW-2:0], ge};
        rem_r[gi]  <= ge ? diff[RW:0] : rem2[RW:0];
        side_r[gi] <= si;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

>>> rtl/core/rsi_div_pipe.sv
module rsi_div_pipe #(
  parameter int unsigned YW     = 65,
  parameter int unsigned QW     = 31,
  parameter int unsigned SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [YW-1:0]     in_rem,
  input  logic [QW-1:0]     in_low,
  input  logic [YW-1:0]     in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_r    [QW];
  logic [YW-1:0]     rem_r  [QW];
  logic [QW-1:0]     low_r  [QW];
  logic [YW-1:0]     div_r  [QW];
  logic [QW-1:0]     quo_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  // restoring divide, one quotient bit per stage
  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic              vi;
    logic [YW-1:0]     ri;
    logic [QW-1:0]     li;
    logic [YW-1:0]     yi;
    logic [QW-1:0]     qi;
    logic [SIDE_W-1:0] si;
    logic [YW:0]       r2;
    logic [YW:0]       diff;
    logic              ge;

    if (gi == 0) begin : g_first
      assign vi = in_valid;
      assign ri = in_rem;
      assign li = in_low;
      assign yi = in_div;
      assign qi = '0;
      assign si = in_side;
    end else begin : g_next
      assign vi = v_r[gi-1];
      assign ri = rem_r[gi-1];
      assign li = low_r[gi-1];
      assign yi = div_r[gi-1];
      assign qi = quo_r[gi-1];
      assign si = side_r[gi-1];
    end

    assign r2   = {ri, li[QW-1]};
    assign ge   = (r2 >= {1'b0, yi});
    assign diff = r2 - {1'b0, yi};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[gi] <= 1'b0;
      end else if (en) begin
        v_r[gi] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi]  <= ge ? diff[YW-1:0] : r2[YW-1:0];
        low_r[gi]  <= {li[QW-2:0], 1'b0};
        div_r[gi]  <= yi;
        quo_r[gi]  <= {qi[QW-2:0], ge};
        side_r[gi] <= si;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
